// ----- rtl/dlp_pkg.sv -----
// dhcp lease pool table: shared types, codes and reset values
// used by dlp_mem, dlp_engine and dhcp_lease_pool_table_core; no dependencies
`timescale 1ns / 1ps

package dlp_pkg;

    localparam int POOL_DEPTH_DEF = 16;

    localparam int IP_W      = 32;
    localparam int COUNT_W   = 5;
    localparam int SEC_W     = 32;
    localparam int ID_W      = 64;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 3;
    localparam int ENTRY_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    // one lease record: {owner_hi, owner_lo, start}
    localparam int MEM_W = 2 * ID_W + SEC_W;

    // operations
    localparam logic [OP_W-1:0] OP_DISCOVER = 2'd0;
    localparam logic [OP_W-1:0] OP_REQUEST  = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK     = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OFFER       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ACK         = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NAK         = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_IN_POOL = 3'd4;
    localparam logic [STATUS_W-1:0] ST_TICK_DONE   = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE_IP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_COUNT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEASE_SECONDS = 2'd2;

    // configuration reset values (192.168.5.3, sixteen entries, one hour)
    localparam logic [IP_W-1:0]    RST_POOL_BASE_IP  = 32'hC0A8_0503;
    localparam logic [COUNT_W-1:0] RST_POOL_COUNT    = 5'd16;
    localparam logic [SEC_W-1:0]   RST_LEASE_SECONDS = 32'd3600;

    typedef struct packed {
        logic [IP_W-1:0]    pool_base_ip;
        logic [COUNT_W-1:0] pool_count;
        logic [SEC_W-1:0]   lease_seconds;
    } t_cfg;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IP_W-1:0]     assigned_ip;
        logic [ENTRY_W-1:0]  entry_index;
    } t_result;

    function automatic t_result mk_result(
        input logic [STATUS_W-1:0] status,
        input logic [IP_W-1:0]     ip,
        input logic [ENTRY_W-1:0]  idx
    );
        t_result r;
        r.status      = status;
        r.assigned_ip = ip;
        r.entry_index = idx;
        return r;
    endfunction

endpackage

// ----- rtl/dlp_mem.sv -----
// lease record memory: one write port, one read port with registered data
// depends on dlp_pkg
`timescale 1ns / 1ps

module dlp_mem
    import dlp_pkg::*;
#(
    parameter int DEPTH  = POOL_DEPTH_DEF,
    parameter int ADDR_W = 4,
    parameter int DATA_W = MEM_W
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/dlp_engine.sv -----
// lease pool sequencer: leased flags, seconds counter, entry scans and
// read-modify-write of the lease memory; depends on dlp_pkg and dlp_mem
`timescale 1ns / 1ps

module dlp_engine
    import dlp_pkg::*;
#(
    parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cfg            i_cfg,
    input  logic            i_start,
    input  logic [OP_W-1:0] i_op,
    input  logic [IP_W-1:0] i_req_ip,
    input  logic [ID_W-1:0] i_id_hi,
    input  logic [ID_W-1:0] i_id_lo,
    output logic            o_idle,
    output logic            o_res_valid,
    output t_result         o_res,
    input  logic            i_res_ready
);

    localparam int IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CNT_W = $clog2(POOL_DEPTH + 1);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DISC    = 3'd1;
    localparam logic [2:0] S_REQ_CHK = 3'd2;
    localparam logic [2:0] S_REQ_CMP = 3'd3;
    localparam logic [2:0] S_TICK    = 3'd4;
    localparam logic [2:0] S_PUSH    = 3'd5;

    logic [2:0]            r_state, n_state;
    logic [IP_W-1:0]       r_req, n_req;
    logic [ID_W-1:0]       r_hi, n_hi;
    logic [ID_W-1:0]       r_lo, n_lo;
    logic [CNT_W-1:0]      r_ptr, n_ptr;
    logic [IDX_W-1:0]      r_off, n_off;
    logic                  r_chk_valid, n_chk_valid;
    logic [IDX_W-1:0]      r_chk_idx, n_chk_idx;
    logic [POOL_DEPTH-1:0] r_leased, n_leased;
    logic [SEC_W-1:0]      r_sec, n_sec;
    t_result               r_res, n_res;

    logic [CNT_W-1:0] w_limit;
    logic [IP_W-1:0]  w_off32;
    logic             w_in_pool;
    logic [IDX_W-1:0] w_ptr_idx;
    logic [31:0]      w_ptr32;
    logic [31:0]      w_roff32;
    logic             w_ptr_more;
    logic [IDX_W-1:0] w_raddr;
    logic             w_we;
    logic [MEM_W-1:0] w_wdata;
    logic [MEM_W-1:0] w_rdata;
    logic [ID_W-1:0]  w_rd_hi;
    logic [ID_W-1:0]  w_rd_lo;
    logic [SEC_W-1:0] w_rd_start;
    logic [SEC_W-1:0] w_age;
    logic             w_expired;

    // entries in use: min(pool_count, depth)
    assign w_limit = (32'(i_cfg.pool_count) > 32'(POOL_DEPTH)) ?
                     CNT_W'(POOL_DEPTH) : CNT_W'(i_cfg.pool_count);

    assign w_off32    = r_req - i_cfg.pool_base_ip;
    assign w_in_pool  = w_off32 < 32'(w_limit);
    assign w_ptr_idx  = r_ptr[IDX_W-1:0];
    assign w_ptr32    = 32'(r_ptr);
    assign w_roff32   = 32'(r_off);
    assign w_ptr_more = w_ptr32 < 32'(POOL_DEPTH);

    assign w_raddr = (r_state == S_TICK) ? w_ptr_idx : w_off32[IDX_W-1:0];
    assign w_wdata = {r_hi, r_lo, r_sec};

    assign w_rd_hi    = w_rdata[MEM_W-1 -: ID_W];
    assign w_rd_lo    = w_rdata[SEC_W +: ID_W];
    assign w_rd_start = w_rdata[SEC_W-1:0];
    assign w_age      = r_sec - w_rd_start;
    assign w_expired  = w_age >= i_cfg.lease_seconds;

    dlp_mem #(
        .DEPTH  (POOL_DEPTH),
        .ADDR_W (IDX_W),
        .DATA_W (MEM_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_off),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_hi        = r_hi;
        n_lo        = r_lo;
        n_ptr       = r_ptr;
        n_off       = r_off;
        n_chk_valid = r_chk_valid;
        n_chk_idx   = r_chk_idx;
        n_leased    = r_leased;
        n_sec       = r_sec;
        n_res       = r_res;
        w_we        = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req = i_req_ip;
                    n_hi  = i_id_hi;
                    n_lo  = i_id_lo;
                    unique case (i_op)
                        OP_DISCOVER: begin
                            n_ptr   = '0;
                            n_state = S_DISC;
                        end
                        OP_REQUEST: begin
                            n_state = S_REQ_CHK;
                        end
                        OP_TICK: begin
                            n_sec       = r_sec + SEC_W'(1);
                            n_ptr       = '0;
                            n_chk_valid = 1'b0;
                            n_state     = S_TICK;
                        end
                        default: begin
                            n_res   = mk_result(ST_NOT_IN_POOL, '0, '0);
                            n_state = S_PUSH;
                        end
                    endcase
                end
            end
            S_DISC: begin
                // first free entry, one flag per cycle
                if (r_ptr >= w_limit) begin
                    n_res   = mk_result(ST_EXHAUSTED, '0, '0);
                    n_state = S_PUSH;
                end else if (!r_leased[w_ptr_idx]) begin
                    n_res   = mk_result(ST_OFFER, i_cfg.pool_base_ip + w_ptr32,
                                        w_ptr32[ENTRY_W-1:0]);
                    n_state = S_PUSH;
                end else begin
                    n_ptr = r_ptr + CNT_W'(1);
                end
            end
            S_REQ_CHK: begin
                if (!w_in_pool) begin
                    n_res   = mk_result(ST_NOT_IN_POOL, '0, '0);
                    n_state = S_PUSH;
                end else begin
                    n_off   = w_off32[IDX_W-1:0];
                    n_state = S_REQ_CMP;
                end
            end
            S_REQ_CMP: begin
                // record read last cycle; free entry or same owner wins
                if (!r_leased[r_off] || (w_rd_hi == r_hi && w_rd_lo == r_lo)) begin
                    w_we            = 1'b1;
                    n_leased[r_off] = 1'b1;
                    n_res = mk_result(ST_ACK, r_req, w_roff32[ENTRY_W-1:0]);
                end else begin
                    n_res = mk_result(ST_NAK, '0, w_roff32[ENTRY_W-1:0]);
                end
                n_state = S_PUSH;
            end
            S_TICK: begin
                // read entry ptr while judging the entry read in the cycle before
                if (w_ptr_more) begin
                    n_ptr       = r_ptr + CNT_W'(1);
                    n_chk_valid = 1'b1;
                    n_chk_idx   = w_ptr_idx;
                end else begin
                    n_chk_valid = 1'b0;
                end
                if (r_chk_valid && r_leased[r_chk_idx] && w_expired) begin
                    n_leased[r_chk_idx] = 1'b0;
                end
                if (!w_ptr_more && !r_chk_valid) begin
                    n_res   = mk_result(ST_TICK_DONE, '0, '0);
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_chk_valid <= 1'b0;
            r_leased    <= '0;
            r_sec       <= '0;
        end else begin
            r_state     <= n_state;
            r_chk_valid <= n_chk_valid;
            r_leased    <= n_leased;
            r_sec       <= n_sec;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_hi      <= n_hi;
        r_lo      <= n_lo;
        r_ptr     <= n_ptr;
        r_off     <= n_off;
        r_chk_idx <= n_chk_idx;
        r_res     <= n_res;
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_PUSH);
    assign o_res       = r_res;

endmodule

// ----- rtl/dhcp_lease_pool_table_core.sv -----
// dhcp lease pool table top level: stream ports, configuration registers,
// output register; depends on dlp_pkg and dlp_engine
`timescale 1ns / 1ps

// Address pool of POOL_DEPTH entries, entry i owning pool_base_ip + i. One
// item is taken at a time and gives exactly one result. A discover scans the
// leased flags one entry per cycle up to the first free one, within the pool
// size in use. A request does an address check with one read of the lease
// memory, then compare and write back, then handoff to the output register;
// an address outside the pool skips the compare and write back. A tick is
// bounded by the single read port of the lease memory that visits every
// entry once. The result then sits in an output register, and the next item
// is accepted while it waits to be taken. Leased flags live in flip-flops
// cleared by reset, so the lease memory needs no clearing pass and the block
// is ready right after reset. Configuration writes are taken at any time but
// must only be issued while the block is idle.
module dhcp_lease_pool_table_core
    import dlp_pkg::*;
#(
    parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input items
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [31:0] requested_ip, [95:32] client_id_hi, [159:96] client_id_lo
    input  logic [159:0]         s_axis_tdata,
    // [1:0] op
    input  logic [1:0]           s_axis_tuser,
    // results
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [31:0] assigned_ip, [35:32] entry_index, [39:36] zero
    output logic [39:0]          m_axis_tdata,
    // [2:0] status
    output logic [2:0]           m_axis_tuser,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_cfg    r_cfg;
    logic    w_start;
    logic    w_idle;
    logic    w_res_valid;
    logic    w_res_ready;
    t_result w_res;
    logic    r_m_valid;
    t_result r_m_res;

    // configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pool_base_ip  <= RST_POOL_BASE_IP;
            r_cfg.pool_count    <= RST_POOL_COUNT;
            r_cfg.lease_seconds <= RST_LEASE_SECONDS;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_POOL_BASE_IP:  r_cfg.pool_base_ip  <= i_cfg_data[IP_W-1:0];
                REG_POOL_COUNT:    r_cfg.pool_count    <= i_cfg_data[COUNT_W-1:0];
                REG_LEASE_SECONDS: r_cfg.lease_seconds <= i_cfg_data[SEC_W-1:0];
                default: begin
                    // writes beyond the register list are dropped
                end
            endcase
        end
    end

    // input side: the sequencer takes a new item only when idle
    assign s_axis_tready = w_idle;
    assign w_start       = s_axis_tvalid & s_axis_tready;

    dlp_engine #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_start     (w_start),
        .i_op        (s_axis_tuser[OP_W-1:0]),
        .i_req_ip    (s_axis_tdata[IP_W-1:0]),
        .i_id_hi     (s_axis_tdata[IP_W +: ID_W]),
        .i_id_lo     (s_axis_tdata[IP_W + ID_W +: ID_W]),
        .o_idle      (w_idle),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ready (w_res_ready)
    );

    // output register decouples the sequencer from a stalled consumer
    assign w_res_ready = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_m_res <= w_res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {4'b0000, r_m_res.entry_index, r_m_res.assigned_ip};
    assign m_axis_tuser  = r_m_res.status;

`ifndef SYNTHESIS
    // a result handed over always shows up on the output next cycle
    a_res_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid && w_res_ready |=> m_axis_tvalid)
        else $error("result handoff lost");

    // one item at a time: no transfer in right after a transfer in
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item accepted while busy");

    // the sequencer never finishes while idle for new input
    a_idle_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_idle |-> !w_res_valid)
        else $error("result offered while idle");

    // status codes stay within the defined set
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser <= ST_TICK_DONE))
        else $error("undefined status code");
`endif

endmodule

// ----- bench/dhcp_lease_pool_table_core_test.sv -----
// self-checking bench for dhcp_lease_pool_table_core: stream driver and monitor,
// an own lease table predictor, config phases; depends on dlp_pkg and the core rtl
`timescale 1ns / 1ps

module dhcp_lease_pool_table_core_test;
    import dlp_pkg::*;

    localparam int POOL_SLOTS    = POOL_DEPTH_DEF;
    localparam int CLIENTS       = 6;
    // the slowest item is a tick, which walks every entry, so this covers any tail
    localparam int SETTLE_CYCLES = POOL_SLOTS + 12;
    localparam int LONG_HOLD     = 300;
    localparam int STALL_LIMIT   = 2000;

    // op value three has no name in the package; the block must answer it as not in pool
    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [IP_W-1:0] req_ip;
        logic [ID_W-1:0] id_hi;
        logic [ID_W-1:0] id_lo;
    } t_dhcp_msg;

    // dut ports; the inputs driven here are known from time zero
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [159:0]         s_axis_tdata  = '0;
    logic [1:0]           s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [39:0]          m_axis_tdata;
    logic [2:0]           m_axis_tuser;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data    = '0;

    // predictor copy of the configuration and the lease table
    logic [IP_W-1:0]    cfg_base_ip    = RST_POOL_BASE_IP;
    logic [COUNT_W-1:0] cfg_pool_count = RST_POOL_COUNT;
    logic [SEC_W-1:0]   cfg_lease_len  = RST_LEASE_SECONDS;
    bit                 slot_leased  [POOL_SLOTS];
    logic [ID_W-1:0]    slot_owner_hi[POOL_SLOTS];
    logic [ID_W-1:0]    slot_owner_lo[POOL_SLOTS];
    logic [SEC_W-1:0]   slot_start   [POOL_SLOTS];
    logic [SEC_W-1:0]   secs_now;

    t_dhcp_msg msg_queue[$];        // items waiting for the driver
    t_result   pending_replies[$];  // predicted replies, oldest first
    t_dhcp_msg on_wire;

    logic [ID_W-1:0] client_hi[CLIENTS];
    logic [ID_W-1:0] client_lo[CLIENTS];

    int error_count  = 0;
    int stall_cycles = 0;
    int hold_request = 0;
    int hold_served  = 0;
    int hold_left    = 0;
    int burst_left   = 0;
    int gap_left     = 0;
    logic [15:0] ready_pattern = 16'hFFFF;
    int          pattern_age   = 0;

    dhcp_lease_pool_table_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // entries in use saturate at the physical pool depth, zero means an empty pool
    function automatic int unsigned pool_in_use();
        return (cfg_pool_count > POOL_SLOTS) ? POOL_SLOTS : cfg_pool_count;
    endfunction

    // one item against the lease table: updates the table, returns the reply
    function automatic t_result lease_table_predict(input t_dhcp_msg m);
        t_result         res;
        logic [IP_W-1:0] offset;
        int unsigned     used;
        bit              found;
        res   = '0;
        used  = pool_in_use();
        found = 1'b0;
        case (m.op)
            OP_DISCOVER: begin
                // lowest free entry wins, nothing gets marked
                res.status = ST_EXHAUSTED;
                for (int i = 0; i < used; i++) begin
                    if (!found && !slot_leased[i]) begin
                        res.status      = ST_OFFER;
                        res.assigned_ip = cfg_base_ip + i;
                        res.entry_index = ENTRY_W'(i);
                        found           = 1'b1;
                    end
                end
            end
            OP_REQUEST: begin
                // offset wraps modulo 2^32, so addresses below the base are out too
                offset = m.req_ip - cfg_base_ip;
                if (offset >= used) begin
                    res.status = ST_NOT_IN_POOL;
                end else if (!slot_leased[offset] ||
                             (slot_owner_hi[offset] == m.id_hi &&
                              slot_owner_lo[offset] == m.id_lo)) begin
                    slot_leased[offset]   = 1'b1;
                    slot_owner_hi[offset] = m.id_hi;
                    slot_owner_lo[offset] = m.id_lo;
                    slot_start[offset]    = secs_now;
                    res.status            = ST_ACK;
                    res.assigned_ip       = m.req_ip;
                    res.entry_index       = offset[ENTRY_W-1:0];
                end else begin
                    res.status      = ST_NAK;
                    res.entry_index = offset[ENTRY_W-1:0];
                end
            end
            OP_TICK: begin
                // expiry walks every entry, also those beyond the pool size in use
                secs_now = secs_now + 1'b1;
                for (int i = 0; i < POOL_SLOTS; i++) begin
                    if (slot_leased[i] && (secs_now - slot_start[i]) >= cfg_lease_len) begin
                        slot_leased[i]   = 1'b0;
                        slot_owner_hi[i] = '0;
                        slot_owner_lo[i] = '0;
                        slot_start[i]    = '0;
                    end
                end
                res.status = ST_TICK_DONE;
            end
            default: res.status = ST_NOT_IN_POOL;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        if (error_count <= 40)
            $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    // ---------------------------------------------------------------------
    // input driver: bursts of random length with random gaps, fed by msg_queue;
    // the reply is predicted at the edge where the transfer happens
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_items
        logic offer;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            offer = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                pending_replies.push_back(lease_table_predict(on_wire));
                offer = 1'b0;
            end
            if (!offer) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (msg_queue.size() > 0) begin
                    on_wire = msg_queue.pop_front();
                    offer   = 1'b1;
                    // tdata: requested_ip, client_id_hi, client_id_lo from bit 0 up
                    s_axis_tdata <= {on_wire.id_lo, on_wire.id_hi, on_wire.req_ip};
                    s_axis_tuser <= on_wire.op;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        // new burst; about a third of bursts follow with no gap
                        burst_left = $urandom_range(0, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
            // single nonblocking write of valid per edge
            s_axis_tvalid <= offer;
        end
    end

    // ---------------------------------------------------------------------
    // reply side ready: a rotating stall pattern, sometimes all ones, plus a
    // long hold-off on request so the core backs up into its input
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_ready
        logic ready_next;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (hold_served != hold_request) begin
                hold_served = hold_request;
                hold_left   = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else begin
                if (pattern_age == 0) begin
                    ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                                : (16'($urandom) | 16'h0001);
                    pattern_age   = $urandom_range(16, 80);
                end
                ready_next    = ready_pattern[0];
                ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
                pattern_age--;
            end
            m_axis_tready <= ready_next;
        end
    end

    // ---------------------------------------------------------------------
    // reply monitor: each transfer against the oldest prediction
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin : check_replies
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_replies.size() == 0) begin
                report_mismatch("reply with none pending", 64'(m_axis_tuser), 64'd0);
            end else begin
                want = pending_replies.pop_front();
                if (m_axis_tuser != want.status)
                    report_mismatch("status", 64'(m_axis_tuser), 64'(want.status));
                if (m_axis_tdata[31:0] != want.assigned_ip)
                    report_mismatch("assigned_ip", 64'(m_axis_tdata[31:0]),
                                    64'(want.assigned_ip));
                if (m_axis_tdata[35:32] != want.entry_index)
                    report_mismatch("entry_index", 64'(m_axis_tdata[35:32]),
                                    64'(want.entry_index));
            end
        end
    end

    // watchdog: any transfer on any channel counts as progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("dhcp_lease_pool_table_core verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ---------------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------------
    function automatic void push_msg(input logic [OP_W-1:0] op, input logic [IP_W-1:0] ip,
                                     input logic [ID_W-1:0] hi, input logic [ID_W-1:0] lo);
        t_dhcp_msg m;
        m.op     = op;
        m.req_ip = ip;
        m.id_hi  = hi;
        m.id_lo  = lo;
        msg_queue.push_back(m);
    endfunction

    // one register write over the config channel, predictor updated on transfer
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_POOL_BASE_IP:  cfg_base_ip    = data;
            REG_POOL_COUNT:    cfg_pool_count = data[COUNT_W-1:0];
            REG_LEASE_SECONDS: cfg_lease_len  = data;
            default: ;
        endcase
    endtask

    // all items taken, every reply seen, then the core gets time to go quiet
    task automatic wait_drained();
        do @(negedge i_clk);
        while (msg_queue.size() != 0 || s_axis_tvalid || pending_replies.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_pool(input logic [IP_W-1:0] base, input logic [COUNT_W-1:0] count,
                            input logic [SEC_W-1:0] lease);
        cfg_write(REG_POOL_BASE_IP, base);
        cfg_write(REG_POOL_COUNT, CFG_DAT_W'(count));
        cfg_write(REG_LEASE_SECONDS, lease);
    endtask

    // requests make the largest share, mostly into the pool, from a small client set so leases collide,
    // renew and expire; the rest is discovers, ticks, stray addresses and op three
    task automatic queue_random_msgs(input int count, input bit with_hold);
        int              roll;
        int              who;
        int unsigned     used;
        logic [IP_W-1:0] addr;
        logic [ID_W-1:0] hi;
        logic [ID_W-1:0] lo;
        @(negedge i_clk);
        used = pool_in_use();
        for (int k = 0; k < count; k++) begin
            roll = $urandom_range(0, 99);
            addr = $urandom;
            hi   = {$urandom, $urandom};
            lo   = {$urandom, $urandom};
            if (roll < 28) begin
                push_msg(OP_DISCOVER, addr, hi, lo);
            end else if (roll < 74) begin
                who = $urandom_range(0, CLIENTS - 1);
                if ($urandom_range(0, 9) != 0) begin
                    hi = client_hi[who];
                    lo = client_lo[who];
                end
                case ($urandom_range(0, 9))
                    0:       ;  // fully random address
                    1:       addr = cfg_base_ip - $urandom_range(1, 3);
                    default: addr = cfg_base_ip + $urandom_range(0, used + 1);
                endcase
                push_msg(OP_REQUEST, addr, hi, lo);
            end else if (roll < 97) begin
                push_msg(OP_TICK, addr, hi, lo);
            end else begin
                push_msg(OP_RESERVED, addr, hi, lo);
            end
        end
        // items are queued, so the sender keeps offering through the hold-off
        if (with_hold)
            hold_request++;
    endtask

    task automatic run_phase(input logic [IP_W-1:0] base, input logic [COUNT_W-1:0] count,
                             input logic [SEC_W-1:0] lease, input int items,
                             input bit with_hold);
        wait_drained();
        set_pool(base, count, lease);
        for (int i = 0; i < CLIENTS; i++) begin
            client_hi[i] = {$urandom, $urandom};
            client_lo[i] = {$urandom, $urandom};
        end
        // two clients apart in one bit of the low half only
        client_hi[1] = client_hi[0];
        client_lo[1] = client_lo[0] ^ 64'd1;
        queue_random_msgs(items / 2, with_hold);
        // sender pauses until the core has answered everything
        wait_drained();
        queue_random_msgs(items - items / 2, 1'b0);
    endtask

    // ---------------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------------
    initial begin : run_test
        logic [ID_W-1:0] a_hi;
        logic [ID_W-1:0] a_lo;
        logic [ID_W-1:0] b_hi;
        logic [ID_W-1:0] b_lo;
        logic [IP_W-1:0] base;

        for (int i = 0; i < POOL_SLOTS; i++) begin
            slot_leased[i]   = 1'b0;
            slot_owner_hi[i] = '0;
            slot_owner_lo[i] = '0;
            slot_start[i]    = '0;
        end
        secs_now = '0;
        a_hi = {$urandom, $urandom};
        a_lo = {$urandom, $urandom};
        b_hi = {$urandom, $urandom};
        b_lo = {$urandom, $urandom};
        base = RST_POOL_BASE_IP;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: offer, claim, clash, renew, ids differing in one half,
        // last entry, just past the pool, just below the base, extreme fields
        @(negedge i_clk);
        push_msg(OP_DISCOVER, $urandom, a_hi, a_lo);
        push_msg(OP_REQUEST, base, a_hi, a_lo);
        push_msg(OP_REQUEST, base, b_hi, b_lo);
        push_msg(OP_REQUEST, base, a_hi, a_lo);
        push_msg(OP_REQUEST, base, a_hi, ~a_lo);
        push_msg(OP_REQUEST, base, ~a_hi, a_lo);
        push_msg(OP_DISCOVER, '0, '0, '0);
        push_msg(OP_REQUEST, base + 15, b_hi, b_lo);
        push_msg(OP_REQUEST, base + 16, b_hi, b_lo);
        push_msg(OP_REQUEST, base - 1, a_hi, a_lo);
        push_msg(OP_REQUEST, '0, '0, '0);
        push_msg(OP_REQUEST, '1, '1, '1);
        push_msg(OP_RESERVED, '1, '1, '1);
        push_msg(OP_RESERVED, '0, '0, '0);
        push_msg(OP_TICK, '1, '1, '1);
        push_msg(OP_TICK, '0, '0, '0);

        // one-entry pool at the top of the address space, one-tick lease:
        // offer, claim, exhausted, wrapped address, expiry, offer again
        wait_drained();
        set_pool('1, 5'd1, 32'd1);
        @(negedge i_clk);
        push_msg(OP_DISCOVER, $urandom, b_hi, b_lo);
        push_msg(OP_REQUEST, '1, a_hi, a_lo);
        push_msg(OP_DISCOVER, $urandom, b_hi, b_lo);
        push_msg(OP_REQUEST, '0, a_hi, a_lo);
        push_msg(OP_TICK, $urandom, a_hi, a_lo);
        push_msg(OP_DISCOVER, $urandom, b_hi, b_lo);

        // empty pool with zero lease length
        wait_drained();
        set_pool('0, 5'd0, '0);
        @(negedge i_clk);
        push_msg(OP_DISCOVER, $urandom, a_hi, a_lo);
        push_msg(OP_REQUEST, '0, a_hi, a_lo);
        push_msg(OP_TICK, $urandom, a_hi, a_lo);

        // random phases across pool sizes and lease lengths, extremes included
        run_phase($urandom,      5'd16, 32'd4, 75, 1'b0);
        run_phase(32'hFFFF_FFF8, 5'd16, 32'd1, 75, 1'b0);
        run_phase($urandom, 5'($urandom_range(1, 16)), $urandom_range(2, 8), 75, 1'b0);
        run_phase('0,            5'd5,  '1,    75, 1'b1);
        run_phase($urandom,      5'd31, 32'd3, 75, 1'b0);
        run_phase($urandom,      5'd1,  32'd2, 75, 1'b0);
        run_phase(RST_POOL_BASE_IP, 5'd8, '0,  75, 1'b0);
        run_phase($urandom, 5'($urandom_range(1, 16)), $urandom_range(1, 6), 75, 1'b0);
        run_phase($urandom,      5'd16, 32'd6, 75, 1'b1);
        run_phase('1,            5'd12, 32'd2, 75, 1'b0);

        wait_drained();
        if (error_count == 0 && pending_replies.size() == 0) begin
            $display("dhcp_lease_pool_table_core verification clean");
        end else begin
            $display("dhcp_lease_pool_table_core verification failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/dlp_pkg.sv
rtl/dlp_mem.sv
rtl/dlp_engine.sv
rtl/dhcp_lease_pool_table_core.sv
bench/dhcp_lease_pool_table_core_test.sv
